// File: rtl/core/cdd_pkg.sv
package cdd_pkg;

  typedef enum logic [2:0] {
    KIND_REGISTER   = 3'd0,
    KIND_UNREGISTER = 3'd1,
    KIND_SCHED      = 3'd2,
    KIND_REFRESH    = 3'd3,
    KIND_POLL       = 3'd4,
    KIND_STOP       = 3'd5
  } kind_t;

  localparam logic [3:0] RES_REGISTERED = 4'd0;
  localparam logic [3:0] RES_ACCEPTED   = 4'd1;
  localparam logic [3:0] RES_SCHED_DISP = 4'd2;
  localparam logic [3:0] RES_REFR_DISP  = 4'd3;
  localparam logic [3:0] RES_DROPPED    = 4'd4;
  localparam logic [3:0] RES_NOT_DUE    = 4'd5;
  localparam logic [3:0] RES_EMPTY      = 4'd6;
  localparam logic [3:0] RES_CLOSED     = 4'd7;
  localparam logic [3:0] RES_FULL       = 4'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  family_id;
    logic [31:0] reg_generation;
    logic [31:0] eligibility_gen;
    logic [31:0] retry_gen;
    logic [31:0] source_gen;
    logic [47:0] not_before;
    logic [47:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  result_kind;
    logic [3:0]  out_family;
    logic [31:0] out_reg_generation;
    logic [31:0] out_eligibility_gen;
    logic [31:0] out_retry_gen;
    logic [31:0] out_source_gen;
    logic [47:0] delay_or_wait;
    logic [31:0] dispatch_total;
    logic [63:0] delay_sum;
    logic [47:0] delay_peak;
    logic [31:0] coalesced_total;
    logic [31:0] dropped_total;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_STAT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture item, clear scan
    logic scan;     // examine slot at scan index in both tables
    logic exec;     // apply the item
    logic stat;     // finish dispatch statistics
    logic emit;     // present result
  } cdd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_taken;
  } cdd_sts_t;

endpackage

// File: rtl/core/cdd_ctrl.sv
module cdd_ctrl
  import cdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_known,
  output logic     in_ready,
  input  cdd_sts_t sts,
  output cdd_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_known) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_STAT;
      end
      ST_STAT: begin
        cmd.stat  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit = 1'b1;
        if (sts.out_taken) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/cdd_dp.sv
module cdd_dp
  import cdd_pkg::*;
#(
  parameter int FAMILIES      = 16,
  parameter int PENDING_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cdd_cmd_t  cmd,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item,
  output cdd_sts_t  sts
);

  localparam int SW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int FW = (FAMILIES > 1) ? $clog2(FAMILIES) : 1;
  localparam logic [63:0] MAX64 = '1;
  localparam logic [31:0] MAX32 = '1;

  in_item_t it_r;

  logic [FAMILIES-1:0] fam_reg_r;
  logic [31:0]         fam_gen_r [FAMILIES];
  logic [31:0]         gen_cnt_r;

  logic [PENDING_SLOTS-1:0] s_valid_r, r_valid_r;
  logic [3:0]  s_fam [PENDING_SLOTS];
  logic [31:0] s_rg  [PENDING_SLOTS];
  logic [31:0] s_eg  [PENDING_SLOTS];
  logic [31:0] s_tg  [PENDING_SLOTS];
  logic [47:0] s_dl  [PENDING_SLOTS];
  logic [47:0] s_qa  [PENDING_SLOTS];
  logic [3:0]  r_fam [PENDING_SLOTS];
  logic [31:0] r_rg  [PENDING_SLOTS];
  logic [31:0] r_sg  [PENDING_SLOTS];
  logic [47:0] r_dl  [PENDING_SLOTS];
  logic [47:0] r_qa  [PENDING_SLOTS];

  logic closing_r;
  logic [31:0] cls_disp_r [2];
  logic [63:0] cls_sum_r  [2];
  logic [47:0] cls_peak_r [2];
  logic [31:0] coal_r, drop_r;

  // scan results, one slot per cycle
  logic [SW-1:0] idx_r;
  logic s_hit_r, r_hit_r, s_free_r, r_free_r, s_any_r, r_any_r;
  logic [SW-1:0] s_hit_i_r, r_hit_i_r, s_free_i_r, r_free_i_r, s_best_r, r_best_r;

  // dispatch bookkeeping
  logic        cls_r;
  logic [47:0] delay_r;
  logic        disp_r;
  logic        out_valid_r;
  out_item_t   res_r;

  logic s_match, r_match, r_cur;
  assign s_match = s_valid_r[idx_r] && s_fam[idx_r] == it_r.family_id
                   && s_rg[idx_r] == it_r.reg_generation;
  assign r_match = r_valid_r[idx_r] && r_fam[idx_r] == it_r.family_id
                   && r_rg[idx_r] == it_r.reg_generation;

  assign sts.scan_last = (32'(idx_r) == PENDING_SLOTS - 1);
  assign sts.out_taken = out_valid_r && out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = res_r;

  function automatic logic is_cur(input logic [FAMILIES-1:0] rg, input logic [31:0] g,
                                  input logic [31:0] fg, input logic [3:0] f);
    logic ok;
    ok = (32'(f) < FAMILIES) && rg[FW'(f)] && fg == g;
    return ok;
  endfunction

  // selected dispatch entry fields
  logic        use_r;
  logic [SW-1:0] ps;
  logic [47:0] pdl, pqa, elig;
  logic [3:0]  pfam;
  logic [31:0] pgen;
  always_comb begin
    use_r = !s_any_r || (r_any_r && r_dl[r_best_r] <= s_dl[s_best_r]);
    ps    = use_r ? r_best_r : s_best_r;
    pdl   = use_r ? r_dl[ps] : s_dl[ps];
    pqa   = use_r ? r_qa[ps] : s_qa[ps];
    pfam  = use_r ? r_fam[ps] : s_fam[ps];
    pgen  = use_r ? r_rg[ps] : s_rg[ps];
    elig  = (pqa > pdl) ? pqa : pdl;
  end

  assign r_cur = is_cur(fam_reg_r, pgen, fam_gen_r[FW'(pfam)], pfam);

  // updated figures of the class just served
  logic [31:0] disp_nxt;
  logic [63:0] sum_nxt;
  logic [47:0] peak_nxt;
  always_comb begin
    disp_nxt = (cls_disp_r[cls_r] == MAX32) ? cls_disp_r[cls_r]
                                            : cls_disp_r[cls_r] + 32'd1;
    sum_nxt  = (cls_sum_r[cls_r] > MAX64 - 64'(delay_r)) ? MAX64
                                                         : cls_sum_r[cls_r] + 64'(delay_r);
    peak_nxt = (delay_r > cls_peak_r[cls_r]) ? delay_r : cls_peak_r[cls_r];
  end

  // result of the item, before statistics
  out_item_t exec_res, stat_res;
  always_comb begin
    exec_res = '0;
    unique case (kind_t'(it_r.kind))
      KIND_REGISTER: begin
        if (32'(it_r.family_id) >= FAMILIES) exec_res.result_kind = RES_FULL;
        else begin
          exec_res.result_kind        = RES_REGISTERED;
          exec_res.out_family         = it_r.family_id;
          exec_res.out_reg_generation = gen_cnt_r + 32'd1;
        end
      end
      KIND_UNREGISTER: exec_res.result_kind = RES_ACCEPTED;
      KIND_SCHED, KIND_REFRESH: begin
        if (closing_r) exec_res.result_kind = RES_CLOSED;
        else if ((kind_t'(it_r.kind) == KIND_SCHED) ? (!s_hit_r && !s_free_r)
                                                     : (!r_hit_r && !r_free_r))
          exec_res.result_kind = RES_FULL;
        else exec_res.result_kind = RES_ACCEPTED;
      end
      KIND_POLL: begin
        if (closing_r) exec_res.result_kind = RES_CLOSED;
        else if (!s_any_r && !r_any_r) exec_res.result_kind = RES_EMPTY;
        else if (pdl > it_r.now_time) begin
          exec_res.result_kind   = RES_NOT_DUE;
          exec_res.delay_or_wait = pdl - it_r.now_time;
        end else begin
          exec_res.result_kind = r_cur ? (use_r ? RES_REFR_DISP : RES_SCHED_DISP)
                                       : RES_DROPPED;
          exec_res.out_family         = pfam;
          exec_res.out_reg_generation = pgen;
          if (use_r) exec_res.out_source_gen = r_sg[ps];
          else begin
            exec_res.out_eligibility_gen = s_eg[ps];
            exec_res.out_retry_gen       = s_tg[ps];
          end
        end
      end
      default: exec_res.result_kind = RES_CLOSED;
    endcase
  end

  // add counters and, for a dispatch, the class figures after this dispatch
  always_comb begin
    stat_res                 = res_r;
    stat_res.coalesced_total = coal_r;
    stat_res.dropped_total   = drop_r;
    if (disp_r) begin
      stat_res.delay_or_wait  = delay_r;
      stat_res.dispatch_total = disp_nxt;
      stat_res.delay_sum      = sum_nxt;
      stat_res.delay_peak     = peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_item;
    if (cmd.scan) begin
      if (s_match && !s_hit_r) s_hit_i_r <= idx_r;
      if (r_match && !r_hit_r) r_hit_i_r <= idx_r;
      if (!s_valid_r[idx_r] && !s_free_r) s_free_i_r <= idx_r;
      if (!r_valid_r[idx_r] && !r_free_r) r_free_i_r <= idx_r;
      if (s_valid_r[idx_r] && (!s_any_r || s_dl[idx_r] < s_dl[s_best_r])) s_best_r <= idx_r;
      if (r_valid_r[idx_r] && (!r_any_r || r_dl[idx_r] < r_dl[r_best_r])) r_best_r <= idx_r;
    end
    if (cmd.exec) begin
      cls_r   <= use_r;
      delay_r <= (it_r.now_time >= elig) ? it_r.now_time - elig : '0;
      res_r   <= exec_res;
    end else if (cmd.stat) begin
      res_r   <= stat_res;
    end
    // write pending stores
    if (cmd.exec && !closing_r) begin
      if (kind_t'(it_r.kind) == KIND_SCHED) begin
        if (!s_hit_r && s_free_r) begin
          s_fam[s_free_i_r] <= it_r.family_id;
          s_rg[s_free_i_r]  <= it_r.reg_generation;
          s_eg[s_free_i_r]  <= it_r.eligibility_gen;
          s_tg[s_free_i_r]  <= it_r.retry_gen;
          s_dl[s_free_i_r]  <= it_r.not_before;
          s_qa[s_free_i_r]  <= it_r.now_time;
        end else if (s_hit_r) begin
          if (it_r.eligibility_gen > s_eg[s_hit_i_r] ||
              (it_r.eligibility_gen == s_eg[s_hit_i_r] &&
               it_r.retry_gen > s_tg[s_hit_i_r])) begin
            s_eg[s_hit_i_r] <= it_r.eligibility_gen;
            s_tg[s_hit_i_r] <= it_r.retry_gen;
            s_dl[s_hit_i_r] <= it_r.not_before;
            s_qa[s_hit_i_r] <= it_r.now_time;
          end else if (it_r.eligibility_gen == s_eg[s_hit_i_r] &&
                       it_r.retry_gen == s_tg[s_hit_i_r] &&
                       it_r.not_before < s_dl[s_hit_i_r])
            s_dl[s_hit_i_r] <= it_r.not_before;
        end
      end
      if (kind_t'(it_r.kind) == KIND_REFRESH) begin
        if (!r_hit_r && r_free_r) begin
          r_fam[r_free_i_r] <= it_r.family_id;
          r_rg[r_free_i_r]  <= it_r.reg_generation;
          r_sg[r_free_i_r]  <= it_r.source_gen;
          r_dl[r_free_i_r]  <= it_r.not_before;
          r_qa[r_free_i_r]  <= it_r.now_time;
        end else if (r_hit_r) begin
          if (it_r.source_gen > r_sg[r_hit_i_r]) r_sg[r_hit_i_r] <= it_r.source_gen;
          if (it_r.not_before < r_dl[r_hit_i_r]) r_dl[r_hit_i_r] <= it_r.not_before;
        end
      end
    end
    if (kind_t'(it_r.kind) == KIND_REGISTER && cmd.exec && 32'(it_r.family_id) < FAMILIES)
      fam_gen_r[FW'(it_r.family_id)] <= gen_cnt_r + 32'd1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fam_reg_r   <= '0;
      gen_cnt_r   <= '0;
      s_valid_r   <= '0;
      r_valid_r   <= '0;
      closing_r   <= 1'b0;
      cls_disp_r  <= '{default: '0};
      cls_sum_r   <= '{default: '0};
      cls_peak_r  <= '{default: '0};
      coal_r      <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      disp_r      <= 1'b0;
      {s_hit_r, r_hit_r, s_free_r, r_free_r, s_any_r, r_any_r} <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
        {s_hit_r, r_hit_r, s_free_r, r_free_r, s_any_r, r_any_r} <= '0;
      end
      if (cmd.scan) begin
        idx_r <= idx_r + SW'(1);
        if (s_match) s_hit_r <= 1'b1;
        if (r_match) r_hit_r <= 1'b1;
        if (!s_valid_r[idx_r]) s_free_r <= 1'b1;
        if (!r_valid_r[idx_r]) r_free_r <= 1'b1;
        if (s_valid_r[idx_r]) s_any_r <= 1'b1;
        if (r_valid_r[idx_r]) r_any_r <= 1'b1;
      end
      if (cmd.exec) begin
        disp_r <= 1'b0;
        unique case (kind_t'(it_r.kind))
          KIND_REGISTER: if (32'(it_r.family_id) < FAMILIES) begin
            gen_cnt_r <= gen_cnt_r + 32'd1;
            fam_reg_r[FW'(it_r.family_id)] <= 1'b1;
          end
          KIND_UNREGISTER: begin
            if (is_cur(fam_reg_r, it_r.reg_generation,
                       fam_gen_r[FW'(it_r.family_id)], it_r.family_id))
              fam_reg_r[FW'(it_r.family_id)] <= 1'b0;
            if (s_hit_r) s_valid_r[s_hit_i_r] <= 1'b0;
            if (r_hit_r) r_valid_r[r_hit_i_r] <= 1'b0;
          end
          KIND_SCHED: if (!closing_r) begin
            if (!s_hit_r && s_free_r) s_valid_r[s_free_i_r] <= 1'b1;
            else if (s_hit_r && (it_r.eligibility_gen > s_eg[s_hit_i_r] ||
                     (it_r.eligibility_gen == s_eg[s_hit_i_r] &&
                      (it_r.retry_gen > s_tg[s_hit_i_r] ||
                       (it_r.retry_gen == s_tg[s_hit_i_r] &&
                        it_r.not_before < s_dl[s_hit_i_r])))))
              coal_r <= (coal_r == MAX32) ? coal_r : coal_r + 32'd1;
          end
          KIND_REFRESH: if (!closing_r) begin
            if (!r_hit_r && r_free_r) r_valid_r[r_free_i_r] <= 1'b1;
            else if (r_hit_r)
              coal_r <= (coal_r == MAX32) ? coal_r : coal_r + 32'd1;
          end
          KIND_POLL: if (!closing_r && (s_any_r || r_any_r) && pdl <= it_r.now_time) begin
            disp_r <= 1'b1;
            if (use_r) r_valid_r[ps] <= 1'b0;
            else       s_valid_r[ps] <= 1'b0;
            if (!r_cur) drop_r <= (drop_r == MAX32) ? drop_r : drop_r + 32'd1;
          end
          default: begin
            closing_r <= 1'b1;
            s_valid_r <= '0;
            r_valid_r <= '0;
          end
        endcase
      end
      if (cmd.stat && disp_r) begin
        cls_disp_r[cls_r] <= disp_nxt;
        cls_sum_r[cls_r]  <= sum_nxt;
        cls_peak_r[cls_r] <= peak_nxt;
      end
      if (cmd.stat) out_valid_r <= 1'b1;
      else if (sts.out_taken) out_valid_r <= 1'b0;
    end
  end

endmodule

// File: rtl/core/coalescing_deadline_dispatcher_core.sv
// Coalescing earliest-deadline dispatcher. For each item the controller
// walks both pending tables one slot per cycle, looking up the key, the first
// free slot and the earliest deadline, then applies the item and updates
// statistics, then holds the result until out_ready. Unknown kinds are
// accepted and give no result. Register, unregister, scheduling and refresh
// requests, poll and stop answer as encoded in the package result codes.
module coalescing_deadline_dispatcher_core
  import cdd_pkg::*;
#(
  parameter int FAMILIES      = 16,
  parameter int PENDING_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  cdd_cmd_t cmd;
  cdd_sts_t sts;
  logic     known;

  // kinds above stop are dropped at the door
  assign known = (in_item.kind <= 3'(KIND_STOP));

  cdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_known (known),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdd_dp #(
    .FAMILIES      (FAMILIES),
    .PENDING_SLOTS (PENDING_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .sts       (sts)
  );

endmodule

// File: tb/sv/coalescing_deadline_dispatcher_core_test.sv
module coalescing_deadline_dispatcher_core_test;
  import cdd_pkg::*;

  localparam int NFAM  = 16;
  localparam int NSLOT = 16;
  localparam bit [47:0] M48 = 48'hFFFF_FFFF_FFFF;
  localparam int LIMIT_CYCLES = 600000;

  // Dispatcher predictor and expected-result queue, kept in one class so the
  // driver tasks only note accepted items and hand over observed results.
  class dispatch_scoreboard;
    bit              fam_reg [NFAM];
    bit [31:0]       fam_gen [NFAM];
    bit [31:0]       gen_ctr;
    bit              s_vld [NSLOT];
    bit [3:0]        s_fam [NSLOT];
    bit [31:0]       s_rgen [NSLOT], s_egen [NSLOT], s_tgen [NSLOT];
    bit [47:0]       s_dl [NSLOT], s_qat [NSLOT];
    bit              r_vld [NSLOT];
    bit [3:0]        r_fam [NSLOT];
    bit [31:0]       r_rgen [NSLOT], r_sgen [NSLOT];
    bit [47:0]       r_dl [NSLOT], r_qat [NSLOT];
    bit              closed;
    bit [31:0]       disp_cnt [2];
    bit [63:0]       dsum [2];
    bit [47:0]       dpeak [2];
    bit [31:0]       coal_cnt, drop_cnt;
    out_item_t       pending_results[$];
    int              mismatches;
    int              results_seen;
    int              dispatch_seen;

    function new();
      gen_ctr = 0; closed = 0; coal_cnt = 0; drop_cnt = 0;
      mismatches = 0; results_seen = 0; dispatch_seen = 0;
      foreach (fam_reg[i]) begin fam_reg[i] = 0; fam_gen[i] = 0; end
      foreach (s_vld[i]) begin s_vld[i] = 0; r_vld[i] = 0; end
      foreach (disp_cnt[c]) begin disp_cnt[c] = 0; dsum[c] = 0; dpeak[c] = 0; end
    endfunction

    function bit current(bit [3:0] f, bit [31:0] g);
      return fam_reg[f] && fam_gen[f] == g;
    endfunction

    function bit [31:0] sat32(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    // Apply one accepted item to the shadow state and queue its result.
    function void note_item(in_item_t it);
      out_item_t r;
      int s, rs, ss, c;
      bit use_r;
      bit [47:0] dl, qat, elig, dly;
      bit [3:0] ef;
      bit [31:0] eg;
      if (it.kind > KIND_STOP) return;   // unknown kind: no result
      r = '0;
      s = -1;
      case (kind_t'(it.kind))
        KIND_REGISTER: begin
          gen_ctr = gen_ctr + 1;
          fam_reg[it.family_id] = 1;
          fam_gen[it.family_id] = gen_ctr;
          r.result_kind = RES_REGISTERED;
          r.out_family = it.family_id;
          r.out_reg_generation = gen_ctr;
        end
        KIND_UNREGISTER: begin
          if (current(it.family_id, it.reg_generation)) fam_reg[it.family_id] = 0;
          for (int i = 0; i < NSLOT; i++)
            if (s_vld[i] && s_fam[i] == it.family_id && s_rgen[i] == it.reg_generation) begin
              s_vld[i] = 0; break;
            end
          for (int i = 0; i < NSLOT; i++)
            if (r_vld[i] && r_fam[i] == it.family_id && r_rgen[i] == it.reg_generation) begin
              r_vld[i] = 0; break;
            end
          r.result_kind = RES_ACCEPTED;
        end
        KIND_SCHED: begin
          if (closed) r.result_kind = RES_CLOSED;
          else begin
            r.result_kind = RES_ACCEPTED;
            for (int i = 0; i < NSLOT && s < 0; i++)
              if (s_vld[i] && s_fam[i] == it.family_id && s_rgen[i] == it.reg_generation)
                s = i;
            if (s < 0) begin
              for (int i = 0; i < NSLOT && s < 0; i++) if (!s_vld[i]) s = i;
              if (s < 0) r.result_kind = RES_FULL;
              else begin
                s_vld[s] = 1; s_fam[s] = it.family_id; s_rgen[s] = it.reg_generation;
                s_egen[s] = it.eligibility_gen; s_tgen[s] = it.retry_gen;
                s_dl[s] = it.not_before; s_qat[s] = it.now_time;
              end
            end else if (it.eligibility_gen > s_egen[s] ||
                         (it.eligibility_gen == s_egen[s] && it.retry_gen > s_tgen[s])) begin
              s_egen[s] = it.eligibility_gen; s_tgen[s] = it.retry_gen;
              s_dl[s] = it.not_before; s_qat[s] = it.now_time;
              coal_cnt = sat32(coal_cnt);
            end else if (it.eligibility_gen == s_egen[s] && it.retry_gen == s_tgen[s] &&
                         it.not_before < s_dl[s]) begin
              s_dl[s] = it.not_before;
              coal_cnt = sat32(coal_cnt);
            end
          end
        end
        KIND_REFRESH: begin
          if (closed) r.result_kind = RES_CLOSED;
          else begin
            r.result_kind = RES_ACCEPTED;
            for (int i = 0; i < NSLOT && s < 0; i++)
              if (r_vld[i] && r_fam[i] == it.family_id && r_rgen[i] == it.reg_generation)
                s = i;
            if (s < 0) begin
              for (int i = 0; i < NSLOT && s < 0; i++) if (!r_vld[i]) s = i;
              if (s < 0) r.result_kind = RES_FULL;
              else begin
                r_vld[s] = 1; r_fam[s] = it.family_id; r_rgen[s] = it.reg_generation;
                r_sgen[s] = it.source_gen; r_dl[s] = it.not_before; r_qat[s] = it.now_time;
              end
            end else begin
              if (it.source_gen > r_sgen[s]) r_sgen[s] = it.source_gen;
              if (it.not_before < r_dl[s]) r_dl[s] = it.not_before;
              coal_cnt = sat32(coal_cnt);
            end
          end
        end
        KIND_POLL: begin
          if (closed) r.result_kind = RES_CLOSED;
          else begin
            rs = -1; ss = -1;
            for (int i = 0; i < NSLOT; i++) begin
              if (r_vld[i] && (rs < 0 || r_dl[i] < r_dl[rs])) rs = i;
              if (s_vld[i] && (ss < 0 || s_dl[i] < s_dl[ss])) ss = i;
            end
            if (rs < 0 && ss < 0) r.result_kind = RES_EMPTY;
            else begin
              use_r = (ss < 0) || (rs >= 0 && r_dl[rs] <= s_dl[ss]);
              dl = use_r ? r_dl[rs] : s_dl[ss];
              if (dl > it.now_time) begin
                r.result_kind = RES_NOT_DUE;
                r.delay_or_wait = dl - it.now_time;
              end else begin
                c = use_r ? 1 : 0;
                if (use_r) begin
                  r_vld[rs] = 0; ef = r_fam[rs]; eg = r_rgen[rs]; qat = r_qat[rs];
                  r.out_source_gen = r_sgen[rs];
                end else begin
                  s_vld[ss] = 0; ef = s_fam[ss]; eg = s_rgen[ss]; qat = s_qat[ss];
                  r.out_eligibility_gen = s_egen[ss];
                  r.out_retry_gen = s_tgen[ss];
                end
                elig = (qat > dl) ? qat : dl;
                dly = (it.now_time >= elig) ? it.now_time - elig : '0;
                disp_cnt[c] = sat32(disp_cnt[c]);
                dsum[c] = (dsum[c] > 64'hFFFF_FFFF_FFFF_FFFF - dly) ?
                          64'hFFFF_FFFF_FFFF_FFFF : dsum[c] + dly;
                if (dly > dpeak[c]) dpeak[c] = dly;
                if (current(ef, eg)) r.result_kind = use_r ? RES_REFR_DISP : RES_SCHED_DISP;
                else begin
                  r.result_kind = RES_DROPPED;
                  drop_cnt = sat32(drop_cnt);
                end
                r.out_family = ef;
                r.out_reg_generation = eg;
                r.delay_or_wait = dly;
                r.dispatch_total = disp_cnt[c];
                r.delay_sum = dsum[c];
                r.delay_peak = dpeak[c];
              end
            end
          end
        end
        default: begin
          closed = 1;
          foreach (s_vld[i]) begin s_vld[i] = 0; r_vld[i] = 0; end
          r.result_kind = RES_CLOSED;
        end
      endcase
      r.coalesced_total = coal_cnt;
      r.dropped_total = drop_cnt;
      pending_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (got.result_kind inside {RES_SCHED_DISP, RES_REFR_DISP, RES_DROPPED})
        dispatch_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  coalescing_deadline_dispatcher_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  dispatch_scoreboard sb;
  int unsigned cycle_count = 0;
  bit          quiet_phase;     // no idling on either side near the end
  bit [47:0]   clock_us;        // advancing time base for requests and polls
  bit [31:0]   issued_gens[$];  // generations handed out so far

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Count cycles; give up on a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Track the assigned generations from register results so requests can use
  // live keys most of the time.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_item.result_kind == RES_REGISTERED)
        issued_gens.push_back(out_item.out_reg_generation);
      sb.check_result(out_item);
    end
  end

  // Receiver: stall in random bursts, except in the quiet phase.
  initial begin
    int burst;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Present one item and hold it until it is accepted.
  task automatic send_item(in_item_t it);
    int burst;
    if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      burst = $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat (burst) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold off until every queued result has been seen.
  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic bit [31:0] pick_gen();
    if (issued_gens.size() != 0 && $urandom_range(0, 9) < 8)
      return issued_gens[$urandom_range(0, issued_gens.size() - 1)];
    return $urandom();
  endfunction

  function automatic in_item_t make_item(kind_t k, bit [3:0] fam);
    in_item_t it;
    it.kind            = k;
    it.family_id       = fam;
    it.reg_generation  = pick_gen();
    it.eligibility_gen = $urandom_range(0, 3);
    it.retry_gen       = $urandom_range(0, 3);
    it.source_gen      = $urandom_range(0, 7);
    it.not_before      = clock_us + $urandom_range(0, 200);
    it.now_time        = clock_us;
    return it;
  endfunction

  function automatic bit [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  initial begin
    in_item_t it;
    kind_t    k;
    int       pick;
    sb = new();
    quiet_phase = 1'b0;
    clock_us = 48'd1000;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty poll, register, both requests, merges, ties, extremes.
    send_item(make_item(KIND_POLL, 4'd0));
    send_item(make_item(KIND_REGISTER, 4'd0));
    send_item(make_item(KIND_REGISTER, 4'd15));
    wait_drained();
    it = make_item(KIND_SCHED, 4'd0);
    it.reg_generation = issued_gens[0]; it.eligibility_gen = 5; it.retry_gen = 5;
    it.not_before = 48'd1100;
    send_item(it);
    it.eligibility_gen = 5; it.retry_gen = 5; it.not_before = 48'd1050;  // lower deadline
    send_item(it);
    it.retry_gen = 6; it.not_before = 48'd1200;                         // newer retry
    send_item(it);
    it.eligibility_gen = 4; it.not_before = 48'd0;                      // older: ignored
    send_item(it);
    it = make_item(KIND_REFRESH, 4'd15);
    it.reg_generation = issued_gens[1]; it.source_gen = 32'hFFFF_FFFF;
    it.not_before = 48'd1200;
    send_item(it);
    it.source_gen = 0; it.not_before = 48'd1300;                        // merge: keep max/min
    send_item(it);
    it = make_item(KIND_POLL, 4'd0); it.now_time = 48'd1100;            // not due
    send_item(it);
    it.now_time = 48'd5000;                                             // refresh wins tie
    send_item(it);
    send_item(it);
    send_item(it);                                                      // empty
    it = make_item(KIND_SCHED, 4'd3);
    it.reg_generation = 32'hFFFF_FFFF; it.eligibility_gen = 32'hFFFF_FFFF;
    it.retry_gen = 32'hFFFF_FFFF; it.not_before = M48; it.now_time = M48;
    send_item(it);                                                      // unregistered key
    it = make_item(KIND_POLL, 4'd0); it.now_time = M48;
    send_item(it);                                                      // dropped
    it.kind = 3'd6; send_item(it);                                      // unknown kinds
    it.kind = 3'd7; send_item(it);
    for (int i = 0; i < NSLOT + 1; i++) begin                           // fill refresh table
      it = make_item(KIND_REFRESH, 4'(i));
      it.reg_generation = 32'(i + 100);
      it.not_before = 48'd0; it.now_time = rand48();
      send_item(it);
    end
    it = make_item(KIND_UNREGISTER, 4'd0); it.reg_generation = issued_gens[0];
    send_item(it);
    send_item(make_item(KIND_STOP, 4'd0));
    send_item(make_item(KIND_SCHED, 4'd1));
    send_item(make_item(KIND_POLL, 4'd1));
    send_item(make_item(KIND_REGISTER, 4'd7));                          // works while closed

    // Random part. A stop is permanent, so it only comes at the very end;
    // everything else mixes live-key requests with noise.
    for (int n = 0; n < 650; n++) begin
      if (n == 300) wait_drained();
      if (n == 560) quiet_phase = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 10) k = KIND_REGISTER;
      else if (pick < 16) k = KIND_UNREGISTER;
      else if (pick < 45) k = KIND_SCHED;
      else if (pick < 70) k = KIND_REFRESH;
      else k = KIND_POLL;
      clock_us = clock_us + $urandom_range(0, 40);
      it = make_item(k, 4'($urandom_range(0, NFAM - 1)));
      if ($urandom_range(0, 19) == 0) begin
        it.eligibility_gen = $urandom(); it.retry_gen = $urandom();
        it.source_gen = $urandom(); it.not_before = rand48();
        it.reg_generation = $urandom();
      end
      if (k == KIND_POLL && $urandom_range(0, 3) == 0) it.now_time = clock_us + 300;
      if (n == 649) it.kind = KIND_STOP;
      send_item(it);
    end

    wait_drained();
    repeat (60) @(negedge clk);
    $display("Covered %0d results, %0d dispatches or drops, closed at the end.",
             sb.results_seen, sb.dispatch_seen);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_results.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
